[sv/bxavg_pkg.sv]
// Shared types and constants of the box-average image downscaler.
`timescale 1ns / 1ps

package bxavg_pkg;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_W      = 12;
  localparam int OW_W       = 11;
  localparam int OH_MAX     = 2048;

  // A block sum holds up to 4095 * 4095 * 255.
  localparam int AREA_W = 2 * DIM_W;
  localparam int QUO_W  = 8;
  localparam int SUM_W  = AREA_W + QUO_W;

  // Restoring division steps for the block sizes.
  localparam int DIV_STEPS = DIM_W;

  // Request queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 4'd0,
    REG_IN_HEIGHT  = 4'd1,
    REG_OUT_WIDTH  = 4'd2,
    REG_OUT_HEIGHT = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CFG_LOAD,
    CFG_DIV,
    CFG_MUL,
    CFG_READY
  } cfg_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [9:0]  out_x;
    logic [10:0] out_y;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    sums_t       sums;
    logic [9:0]  out_x;
    logic [10:0] out_y;
  } qent_t;

  // Frame geometry derived from the size registers.
  typedef struct packed {
    logic              ready;
    logic [DIM_W-1:0]  iw;
    logic [DIM_W-1:0]  ih;
    logic [OW_W-1:0]   ow;
    logic [DIM_W-1:0]  oh;
    logic [DIM_W-1:0]  bw;
    logic [DIM_W-1:0]  bh;
    logic [OW_W-1:0]   rw;
    logic [DIM_W-1:0]  rh;
    logic [AREA_W-1:0] area;
  } geom_t;

endpackage

[sv/bxavg_cfg.sv]
// Size registers and the sequencer that derives block sizes from them.
`timescale 1ns / 1ps

module bxavg_cfg #(
  parameter int MAX_IN_WIDTH  = 2048,
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data,
  output bxavg_pkg::geom_t                geom
);

  localparam int DW = bxavg_pkg::DIM_W;
  localparam int OW = bxavg_pkg::OW_W;

  logic [DW-1:0] in_width_r, in_height_r, out_height_r;
  logic [OW-1:0] out_width_r;

  bxavg_pkg::cfg_state_t state_r, state_nxt;

  logic [DW-1:0] iw_r, ih_r, oh_r;
  logic [OW-1:0] ow_r;
  logic [DW-1:0] a_num_r, a_rem_r, b_num_r, b_rem_r;
  logic [3:0]    cnt_r;
  logic [bxavg_pkg::AREA_W-1:0] area_r;

  logic          reg_hit;
  logic [DW-1:0] eff_iw, eff_ih, eff_oh, eff_c;
  logic [DW:0]   a_trial, b_trial;
  logic          a_bit, b_bit;
  logic [DW-1:0] a_rem_nxt, b_rem_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    reg_hit = 1'b0;
    unique case (cfg_index)
      bxavg_pkg::REG_IN_WIDTH,
      bxavg_pkg::REG_IN_HEIGHT,
      bxavg_pkg::REG_OUT_WIDTH,
      bxavg_pkg::REG_OUT_HEIGHT: reg_hit = cfg_valid;
      default:                   reg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= 12'd640;
      in_height_r  <= 12'd480;
      out_width_r  <= 11'd320;
      out_height_r <= 12'd240;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bxavg_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_data;
        bxavg_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_data;
        bxavg_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_data[OW-1:0];
        bxavg_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, output never larger than input.
  always_comb begin
    eff_iw = (in_width_r == '0) ? DW'(1) : in_width_r;
    if (32'(eff_iw) > MAX_IN_WIDTH) begin
      eff_iw = DW'(MAX_IN_WIDTH);
    end
    eff_c = (out_width_r == '0) ? DW'(1) : {1'b0, out_width_r};
    if (eff_c > eff_iw) begin
      eff_c = eff_iw;
    end
    if (32'(eff_c) > MAX_OUT_WIDTH) begin
      eff_c = DW'(MAX_OUT_WIDTH);
    end
    eff_ih = (in_height_r == '0) ? DW'(1) : in_height_r;
    eff_oh = (out_height_r == '0) ? DW'(1) : out_height_r;
    if (eff_oh > eff_ih) begin
      eff_oh = eff_ih;
    end
    if (32'(eff_oh) > bxavg_pkg::OH_MAX) begin
      eff_oh = DW'(bxavg_pkg::OH_MAX);
    end
  end

  // One restoring step of each width and height division.
  always_comb begin
    a_trial   = {a_rem_r, a_num_r[DW-1]};
    a_bit     = a_trial >= {2'b00, ow_r};
    a_rem_nxt = a_bit ? DW'(a_trial - {2'b00, ow_r}) : DW'(a_trial);
    b_trial   = {b_rem_r, b_num_r[DW-1]};
    b_bit     = b_trial >= {1'b0, oh_r};
    b_rem_nxt = b_bit ? DW'(b_trial - {1'b0, oh_r}) : DW'(b_trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bxavg_pkg::CFG_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bxavg_pkg::CFG_LOAD:  state_nxt = bxavg_pkg::CFG_DIV;
      bxavg_pkg::CFG_DIV: begin
        if (cnt_r == 4'(bxavg_pkg::DIV_STEPS - 1)) begin
          state_nxt = bxavg_pkg::CFG_MUL;
        end
      end
      bxavg_pkg::CFG_MUL:   state_nxt = bxavg_pkg::CFG_READY;
      bxavg_pkg::CFG_READY: state_nxt = bxavg_pkg::CFG_READY;
      default:              state_nxt = bxavg_pkg::CFG_LOAD;
    endcase
    if (reg_hit) begin
      state_nxt = bxavg_pkg::CFG_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bxavg_pkg::CFG_LOAD: begin
        iw_r    <= eff_iw;
        ih_r    <= eff_ih;
        ow_r    <= OW'(eff_c);
        oh_r    <= eff_oh;
        a_num_r <= eff_iw;
        b_num_r <= eff_ih;
        a_rem_r <= '0;
        b_rem_r <= '0;
        cnt_r   <= '0;
      end
      bxavg_pkg::CFG_DIV: begin
        a_num_r <= {a_num_r[DW-2:0], a_bit};
        b_num_r <= {b_num_r[DW-2:0], b_bit};
        a_rem_r <= a_rem_nxt;
        b_rem_r <= b_rem_nxt;
        cnt_r   <= cnt_r + 4'd1;
      end
      bxavg_pkg::CFG_MUL: begin
        area_r <= {{DW{1'b0}}, a_num_r} * {{DW{1'b0}}, b_num_r};
      end
      default: ;
    endcase
  end

  assign geom.ready = (state_r == bxavg_pkg::CFG_READY);
  assign geom.iw    = iw_r;
  assign geom.ih    = ih_r;
  assign geom.ow    = ow_r;
  assign geom.oh    = oh_r;
  assign geom.bw    = a_num_r;
  assign geom.bh    = b_num_r;
  assign geom.rw    = a_rem_r[OW-1:0];
  assign geom.rh    = b_rem_r;
  assign geom.area  = area_r;

  a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    reg_hit |=> state_r == bxavg_pkg::CFG_LOAD)
    else $error("size write did not restart the block size sequence");

endmodule

[sv/bxavg_front.sv]
// Front part: frame position tracking, block classification and line sums.
`timescale 1ns / 1ps

module bxavg_front #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bxavg_pkg::geom_t      geom,
  input  logic                  in_push,
  output logic                  in_full,
  input  bxavg_pkg::pix_t       in_data,
  output logic                  q_push,
  input  logic                  q_full,
  output bxavg_pkg::qent_t      q_data
);

  localparam int DW    = bxavg_pkg::DIM_W;
  localparam int OW    = bxavg_pkg::OW_W;
  localparam int SW    = bxavg_pkg::SUM_W;
  localparam int OC_W  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int AW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  // Frame position.
  logic [DW-1:0]   in_col_r, in_row_r;
  logic [OC_W-1:0] out_col_r;
  logic [DW-1:0]   col_start_r, out_row_r, row_start_r, row_rem_r;
  logic [OW-1:0]   col_rem_r;
  logic [DW-1:0]   in_col_nxt, in_row_nxt, col_start_nxt, out_row_nxt;
  logic [DW-1:0]   row_start_nxt, row_rem_nxt;
  logic [OC_W-1:0] out_col_nxt;
  logic [OW-1:0]   col_rem_nxt;

  // Accumulate stage.
  logic                 s1_valid_r, s1_acc_r, s1_first_r, s1_emit_r;
  logic [AW-1:0]        s1_k_r;
  logic [9:0]           s1_x_r;
  logic [10:0]          s1_y_r;
  bxavg_pkg::pix_t      s1_pix_r;
  bxavg_pkg::sums_t     rd_r, fwd_r, base, s1_sum;
  logic                 fwd_hit_r;

  bxavg_pkg::sums_t     line_mem [MAX_OUT_WIDTH];

  logic        accept, s1_stall, s1_adv, s1_wr;
  logic [DW:0] col_end, row_end;
  logic        in_cblk, in_rblk, last_c, last_r, first, acc, emit;
  logic [DW-1:0] col_rsum;
  logic [DW:0]   row_rsum;
  logic          col_carry, row_carry;
  logic [AW-1:0] k_new;

  always_comb begin
    col_end = {1'b0, col_start_r} + {1'b0, geom.bw};
    row_end = {1'b0, row_start_r} + {1'b0, geom.bh};
    in_cblk = (in_col_r >= col_start_r) && ({1'b0, in_col_r} < col_end);
    in_rblk = (in_row_r >= row_start_r) && ({1'b0, in_row_r} < row_end);
    last_c  = in_cblk && (({1'b0, in_col_r} + (DW + 1)'(1)) == col_end);
    last_r  = in_rblk && (({1'b0, in_row_r} + (DW + 1)'(1)) == row_end);
    first   = (in_row_r == row_start_r) && (in_col_r == col_start_r);
    acc     = in_cblk && in_rblk;
    emit    = acc && last_c && last_r;
    k_new   = out_col_r[AW-1:0];
  end

  assign s1_stall = s1_valid_r && s1_emit_r && q_full;
  assign s1_adv   = s1_valid_r && !s1_stall;
  assign s1_wr    = s1_adv && s1_acc_r;
  assign in_full  = !geom.ready || s1_stall;
  assign accept   = in_push && !in_full;

  // Block starts advance as floor(k * in / out) by carrying the remainder.
  always_comb begin
    col_rsum  = {1'b0, col_rem_r} + {1'b0, geom.rw};
    col_carry = col_rsum >= {1'b0, geom.ow};
    row_rsum  = {1'b0, row_rem_r} + {1'b0, geom.rh};
    row_carry = row_rsum >= {1'b0, geom.oh};

    in_col_nxt    = in_col_r + DW'(1);
    in_row_nxt    = in_row_r;
    out_col_nxt   = out_col_r;
    col_start_nxt = col_start_r;
    col_rem_nxt   = col_rem_r;
    out_row_nxt   = out_row_r;
    row_start_nxt = row_start_r;
    row_rem_nxt   = row_rem_r;

    if (last_c) begin
      out_col_nxt   = out_col_r + OC_W'(1);
      col_start_nxt = col_start_r + geom.bw + DW'(col_carry);
      col_rem_nxt   = col_carry ? OW'(col_rsum - {1'b0, geom.ow}) : OW'(col_rsum);
    end

    if (in_col_nxt == geom.iw) begin
      in_col_nxt    = '0;
      out_col_nxt   = '0;
      col_start_nxt = '0;
      col_rem_nxt   = '0;
      if (last_r) begin
        out_row_nxt   = out_row_r + DW'(1);
        row_start_nxt = row_start_r + geom.bh + DW'(row_carry);
        row_rem_nxt   = row_carry ? DW'(row_rsum - {1'b0, geom.oh}) : DW'(row_rsum);
      end
      in_row_nxt = in_row_r + DW'(1);
      if (in_row_nxt == geom.ih) begin
        in_row_nxt    = '0;
        out_row_nxt   = '0;
        row_start_nxt = '0;
        row_rem_nxt   = '0;
      end
    end
  end

  // Position restarts while the geometry is being worked out.
  always_ff @(posedge clk) begin
    if (!rst_n || !geom.ready) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      col_start_r <= '0;
      col_rem_r   <= '0;
      out_row_r   <= '0;
      row_start_r <= '0;
      row_rem_r   <= '0;
    end else if (accept) begin
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      col_start_r <= col_start_nxt;
      col_rem_r   <= col_rem_nxt;
      out_row_r   <= out_row_nxt;
      row_start_r <= row_start_nxt;
      row_rem_r   <= row_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_acc_r   <= acc;
      s1_first_r <= first;
      s1_emit_r  <= emit;
      s1_k_r     <= k_new;
      s1_x_r     <= 10'(out_col_r);
      s1_y_r     <= 11'(out_row_r);
      s1_pix_r   <= in_data;
      fwd_hit_r  <= s1_wr && (s1_k_r == k_new);
      fwd_r      <= s1_sum;
    end
  end

  // The read of a pixel meets the write of the one before it; bypass that write.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[k_new];
    end
    if (s1_wr) begin
      line_mem[s1_k_r] <= s1_sum;
    end
  end

  always_comb begin
    base = fwd_hit_r ? fwd_r : rd_r;
    if (s1_first_r) begin
      s1_sum.red   = SW'(s1_pix_r.red);
      s1_sum.green = SW'(s1_pix_r.green);
      s1_sum.blue  = SW'(s1_pix_r.blue);
    end else begin
      s1_sum.red   = base.red + SW'(s1_pix_r.red);
      s1_sum.green = base.green + SW'(s1_pix_r.green);
      s1_sum.blue  = base.blue + SW'(s1_pix_r.blue);
    end
  end

  assign q_push       = s1_adv && s1_emit_r;
  assign q_data.sums  = s1_sum;
  assign q_data.out_x = s1_x_r;
  assign q_data.out_y = s1_y_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_stall |=> s1_valid_r && $stable(s1_k_r) && $stable(s1_emit_r))
    else $error("stalled accumulate stage lost its pixel");

  a_starts_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    geom.ready |-> (col_start_r <= geom.iw) && (row_start_r <= geom.ih))
    else $error("block start ran past the frame edge");

endmodule

[sv/bxavg_fifo.sv]
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

module bxavg_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  bxavg_pkg::qent_t wr_data,
  input  logic             pop,
  output logic             empty,
  output bxavg_pkg::qent_t rd_data
);

  localparam int AW = bxavg_pkg::Q_AW;

  bxavg_pkg::qent_t  slots_r [bxavg_pkg::Q_DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [AW:0]       count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == (AW + 1)'(bxavg_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + (AW + 1)'(1))
    else $error("queue fill count missed a request");

endmodule

[sv/bxavg_back.sv]
// Back part: per-channel block averaging divider and the result register.
`timescale 1ns / 1ps

module bxavg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bxavg_pkg::AREA_W-1:0]  area,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  bxavg_pkg::qent_t              q_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output bxavg_pkg::result_t            out_data
);

  localparam int SW = bxavg_pkg::SUM_W;
  localparam int QW = bxavg_pkg::QUO_W;

  bxavg_pkg::back_state_t state_r, state_nxt;

  logic [SW-1:0]     rem_r [3];
  logic [QW-1:0]     quo_r [3];
  logic [SW-1:0]     rem_nxt [3];
  logic              bit_nxt [3];
  logic [$clog2(QW)-1:0] cnt_r;
  logic [9:0]        x_r;
  logic [10:0]       y_r;
  logic [SW-1:0]     dvs;

  logic                 out_valid_r;
  bxavg_pkg::result_t   out_r;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == bxavg_pkg::BK_IDLE) && !q_empty;

  // Quotients stay below 256 because every pixel is at most 255.
  always_comb begin
    dvs = SW'(area) << cnt_r;
    for (int c = 0; c < 3; c++) begin
      bit_nxt[c] = rem_r[c] >= dvs;
      rem_nxt[c] = bit_nxt[c] ? rem_r[c] - dvs : rem_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bxavg_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bxavg_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = bxavg_pkg::BK_DIV;
        end
      end
      bxavg_pkg::BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = bxavg_pkg::BK_DONE;
        end
      end
      bxavg_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = bxavg_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bxavg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bxavg_pkg::BK_IDLE: begin
        rem_r[0] <= q_data.sums.red;
        rem_r[1] <= q_data.sums.green;
        rem_r[2] <= q_data.sums.blue;
        x_r      <= q_data.out_x;
        y_r      <= q_data.out_y;
        cnt_r    <= ($clog2(QW))'(QW - 1);
      end
      bxavg_pkg::BK_DIV: begin
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= rem_nxt[c];
          quo_r[c] <= {quo_r[c][QW-2:0], bit_nxt[c]};
        end
        cnt_r <= cnt_r - ($clog2(QW))'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bxavg_pkg::BK_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bxavg_pkg::BK_DONE && out_free) begin
      out_r.avg_red   <= quo_r[0];
      out_r.avg_green <= quo_r[1];
      out_r.avg_blue  <= quo_r[2];
      out_r.out_x     <= x_r;
      out_r.out_y     <= y_r;
    end
  end

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r)
    else $error("waiting result was dropped");

endmodule

[sv/box_average_image_downscale.sv]
// Top level of the box-average image downscaler.
`timescale 1ns / 1ps

// Shrinks a raster-order RGB stream by averaging rectangular blocks of pixels.
// Input pixels are pushed with in_push while in_full is low, one per cycle at
// most. Every pixel that closes a block produces one result request on the
// output queue: empty low shows the oldest result, out_pop takes it.
// The four size registers are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high); the user must write them only while the block
// is idle, which the block itself does not enforce. A size write restarts the
// frame at its top-left pixel and starts a sequence that divides the sizes
// into block sizes and block area; in_full stays high meanwhile. The same
// sequence runs after reset, which restores 640x480 down to 320x240. The
// front part takes one pixel per cycle unless a closing pixel waits on a full
// queue; a line memory with one entry per output column holds the running
// block sums, read into a register as a pixel is accepted, with a bypass of
// the previous write. Results cross a four-entry request queue to the back
// part, whose shift-subtract divider takes one request at a time. Closing
// pixels come one per block width on the last row of a block row. A closing
// pixel's result passes the accumulate stage, the request queue, the divider
// and the result register. When the receiver stalls, the result register,
// the divider and the queue fill in turn before in_full rises.

module box_average_image_downscale #(
  parameter int MAX_IN_WIDTH  = 2048,
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  bxavg_pkg::pix_t                  in_data,
  output logic                             out_empty,
  input  logic                             out_pop,
  output bxavg_pkg::result_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data
);

  bxavg_pkg::geom_t geom;
  bxavg_pkg::qent_t q_wr_data, q_rd_data;
  logic             q_push, q_full, q_pop, q_empty;

  // Sizes and the block geometry derived from them.
  bxavg_cfg #(
    .MAX_IN_WIDTH  (MAX_IN_WIDTH),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // Classifies each pixel and accumulates it into its block sum.
  bxavg_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wr_data)
  );

  // Finished block sums waiting for the divider.
  bxavg_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // Divides each sum by the block area and holds the result for the receiver.
  bxavg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .area      (geom.area),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the box-average image downscaler.
`timescale 1ns / 1ps

module tb;

  // Geometry limits of the block as instantiated (default parameters).
  localparam int unsigned MAX_IN_W  = 2048;
  localparam int unsigned MAX_OUT_W = 1024;

  // Cycles to let pass after the last expected result before a size write or
  // the end of the run, so that pixels that close no block have left the front
  // part too.
  localparam int unsigned SETTLE_CYCLES = 30;

  // Hard stop for a hung run, far above the slowest correct run.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  localparam int unsigned MAX_REPORTS = 10;

  // How the two sides of the queue interface insert gaps.
  typedef enum {
    GAP_SEND_HEAVY,
    GAP_RECV_HEAVY,
    GAP_NONE
  } gap_mode_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  bxavg_pkg::pix_t      in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  bxavg_pkg::result_t   out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index = bxavg_pkg::REG_IN_WIDTH;
  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  box_average_image_downscale uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-time limit. It only fires when the run hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb failed");
    $finish;
  end

  gap_mode_t gap_mode = GAP_SEND_HEAVY;
  int unsigned mismatches = 0;

  // Finished output pixels that the stream has already earned, oldest first.
  bxavg_pkg::result_t pending_blocks[$];

  // ---------------------------------------------------------------------------
  // Downscaler prediction. It keeps its own copy of the size registers, the
  // line of per-block channel sums and the frame position counters.
  // ---------------------------------------------------------------------------
  logic [11:0] sz_in_w, sz_in_h, sz_out_h;
  logic [10:0] sz_out_w;

  longint unsigned acc_red[MAX_OUT_W];
  longint unsigned acc_green[MAX_OUT_W];
  longint unsigned acc_blue[MAX_OUT_W];

  int unsigned col_pos, row_pos;       // position of the next input pixel
  int unsigned blk_col, blk_col_x0;    // current block column and its first column
  int unsigned blk_row, blk_row_y0;    // current block row and its first row

  // A size write or a reset puts the next pixel at the top-left corner.
  function automatic void restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    blk_col    = 0;
    blk_col_x0 = 0;
    blk_row    = 0;
    blk_row_y0 = 0;
  endfunction

  function automatic logic [7:0] block_mean(longint unsigned total, longint unsigned area);
    longint unsigned q;
    q = total / area;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Folds one accepted pixel into the running sums and queues the averaged
  // pixel when this one closes a block (its bottom-right corner).
  function automatic void accumulate_pixel(bxavg_pkg::pix_t px);
    int unsigned iw, ih, ow, oh, bw, bh, k;
    bit in_cblk, in_rblk, last_c, last_r;
    bxavg_pkg::result_t res;
    // Zero sizes count as one; out sizes never exceed in sizes or the limits.
    iw = (sz_in_w == 0) ? 1 : sz_in_w;
    ih = (sz_in_h == 0) ? 1 : sz_in_h;
    ow = (sz_out_w == 0) ? 1 : sz_out_w;
    oh = (sz_out_h == 0) ? 1 : sz_out_h;
    if (iw > MAX_IN_W) iw = MAX_IN_W;
    if (ow > iw) ow = iw;
    if (ow > MAX_OUT_W) ow = MAX_OUT_W;
    if (oh > ih) oh = ih;
    if (oh > bxavg_pkg::OH_MAX) oh = bxavg_pkg::OH_MAX;
    bw = iw / ow;
    bh = ih / oh;

    in_cblk = (col_pos >= blk_col_x0) && (col_pos < blk_col_x0 + bw);
    in_rblk = (row_pos >= blk_row_y0) && (row_pos < blk_row_y0 + bh);
    last_c  = in_cblk && (col_pos == blk_col_x0 + bw - 1);
    last_r  = in_rblk && (row_pos == blk_row_y0 + bh - 1);

    if (in_cblk && in_rblk && blk_col < MAX_OUT_W) begin
      k = blk_col;
      // The first pixel of a block overwrites whatever the entry held.
      if (row_pos == blk_row_y0 && col_pos == blk_col_x0) begin
        acc_red[k]   = px.red;
        acc_green[k] = px.green;
        acc_blue[k]  = px.blue;
      end else begin
        acc_red[k]   += px.red;
        acc_green[k] += px.green;
        acc_blue[k]  += px.blue;
      end
      if (last_c && last_r) begin
        res.avg_red   = block_mean(acc_red[k], longint'(bw) * bh);
        res.avg_green = block_mean(acc_green[k], longint'(bw) * bh);
        res.avg_blue  = block_mean(acc_blue[k], longint'(bw) * bh);
        res.out_x     = blk_col[9:0];
        res.out_y     = blk_row[10:0];
        pending_blocks.push_back(res);
      end
    end

    if (last_c) begin
      blk_col++;
      blk_col_x0 = (blk_col < ow) ? (blk_col * iw) / ow : iw;
    end

    // End of an input line, and after the last line the frame wraps.
    col_pos++;
    if (col_pos >= iw) begin
      col_pos    = 0;
      blk_col    = 0;
      blk_col_x0 = 0;
      if (last_r) begin
        blk_row++;
        blk_row_y0 = (blk_row < oh) ? (blk_row * ih) / oh : ih;
      end
      row_pos++;
      if (row_pos >= ih) begin
        row_pos    = 0;
        blk_row    = 0;
        blk_row_y0 = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------
  function automatic int unsigned gap_pct(bit sender);
    case (gap_mode)
      GAP_SEND_HEAVY: return sender ? 29 : 51;
      GAP_RECV_HEAVY: return sender ? 51 : 29;
      default:        return 0;
    endcase
  endfunction

  // Channel values lean toward the extremes now and then.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bxavg_pkg::pix_t pick_pixel();
    bxavg_pkg::pix_t px;
    px.red   = pick_channel();
    px.green = pick_channel();
    px.blue  = pick_channel();
    return px;
  endfunction

  // Sends one pixel request. in_push only changes when the sender idles, so
  // back-to-back requests keep it high without a glitch inside a time step.
  // in_full is read right after the edge, i.e. the value the edge saw.
  task automatic send_pixel(input bxavg_pkg::pix_t px);
    while ($urandom_range(99) < gap_pct(1'b1)) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_full) @(posedge clk);
    accumulate_pixel(px);
  endtask

  // Waits until every earned result has been taken, then lets the pipeline
  // settle so that pixels that close no block have left the front part too.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the size registers selected by the mask, back to back, once the
  // block is idle. cfg_valid stays high across the writes and drops once.
  task automatic configure_frame(input bit [3:0] mask, input logic [11:0] iw,
                                 input logic [11:0] ih, input logic [11:0] ow,
                                 input logic [11:0] oh);
    bxavg_pkg::cfg_reg_t order[4];
    logic [11:0]         vals[4];
    order = '{bxavg_pkg::REG_IN_WIDTH, bxavg_pkg::REG_IN_HEIGHT,
              bxavg_pkg::REG_OUT_WIDTH, bxavg_pkg::REG_OUT_HEIGHT};
    vals  = '{iw, ih, ow, oh};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= order[i];
        cfg_data  <= vals[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (order[i])
          bxavg_pkg::REG_IN_WIDTH:   sz_in_w  = vals[i];
          bxavg_pkg::REG_IN_HEIGHT:  sz_in_h  = vals[i];
          bxavg_pkg::REG_OUT_WIDTH:  sz_out_w = vals[i][10:0];
          bxavg_pkg::REG_OUT_HEIGHT: sz_out_h = vals[i];
          default: ;
        endcase
        restart_frame();
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop with the current gap mode, and a check of each
  // accepted result against the oldest earned one.
  // ---------------------------------------------------------------------------
  bxavg_pkg::result_t want;

  task automatic report_mismatch(input string what, input bxavg_pkg::result_t exp_px,
                                 input bxavg_pkg::result_t got_px);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected rgb %02h %02h %02h at (%0d,%0d), got %02h %02h %02h at (%0d,%0d)",
               $realtime, what, exp_px.avg_red, exp_px.avg_green, exp_px.avg_blue,
               exp_px.out_x, exp_px.out_y, got_px.avg_red, got_px.avg_green,
               got_px.avg_blue, got_px.out_x, got_px.out_y);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch("result with none expected", '0, out_data);
        end else begin
          want = pending_blocks.pop_front();
          if (out_data.avg_red !== want.avg_red || out_data.avg_green !== want.avg_green ||
              out_data.avg_blue !== want.avg_blue || out_data.out_x !== want.out_x ||
              out_data.out_y !== want.out_y)
            report_mismatch("wrong result", want, out_data);
        end
      end
      out_pop <= ($urandom_range(99) >= gap_pct(1'b0));
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // A 5x2 image to 2x1: 2x2 blocks, the last column belongs to no block and
  // must be skipped. Red and green alternate between full scale and zero.
  task automatic test_skipped_edges();
    bxavg_pkg::pix_t px;
    configure_frame(4'hF, 12'd5, 12'd2, 12'd2, 12'd1);
    for (int i = 0; i < 10; i++) begin
      px.red   = (i % 2 == 0) ? 8'hFF : 8'h00;
      px.green = ~px.red;
      px.blue  = 8'($urandom);
      send_pixel(px);
    end
  endtask

  // All sizes zero count as 1x1: every pixel is a block and the frame wraps
  // after each one.
  task automatic test_zero_sizes();
    configure_frame(4'hF, 12'd0, 12'd0, 12'd0, 12'd0);
    send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00});
    send_pixel(pick_pixel());
    send_pixel(pick_pixel());
  endtask

  // Register extremes: input width beyond the line limit, output width beyond
  // the output line limit, output height beyond input height.
  task automatic test_oversized_sizes();
    configure_frame(4'hF, 12'hFFF, 12'd0, 12'h7FF, 12'hFFF);
    repeat (6) send_pixel(pick_pixel());
  endtask

  // A size write mid-frame restarts at the top-left pixel, even when the
  // value does not change.
  task automatic test_restart_on_write();
    configure_frame(4'hF, 12'd2, 12'd2, 12'd1, 12'd1);
    repeat (2) send_pixel(pick_pixel());
    configure_frame(4'b1000, 12'd0, 12'd0, 12'd0, 12'd1);
    repeat (4) send_pixel(pick_pixel());
  endtask

  // One column, tallest input, tallest output: block rows start at uneven
  // positions and some input rows fall between blocks.
  task automatic test_tall_column();
    configure_frame(4'hF, 12'd0, 12'hFFF, 12'd1, 12'd2048);
    repeat (40) send_pixel(pick_pixel());
  endtask

  // One block of 64x4 pixels, with red at full scale throughout.
  task automatic test_wide_block();
    bxavg_pkg::pix_t px;
    configure_frame(4'hF, 12'd64, 12'd4, 12'd1, 12'd1);
    repeat (256) begin
      px       = pick_pixel();
      px.red   = 8'hFF;
      send_pixel(px);
    end
  endtask

  // Random small frames, whole or cut short by the next size write. Output
  // sizes sometimes exceed the input or are zero to hit the clipping paths.
  task automatic test_random_frames(input gap_mode_t mode, input int unsigned n_pix);
    int unsigned sent, iw, ih, ow, oh, frame_px, total;
    gap_mode = mode;
    sent = 0;
    while (sent < n_pix) begin
      iw = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
      ih = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
      if ($urandom_range(7) == 0) ow = $urandom_range(15, 0);
      else ow = $urandom_range((iw == 0) ? 1 : iw, 1);
      if ($urandom_range(7) == 0) oh = $urandom_range(10, 0);
      else oh = $urandom_range((ih == 0) ? 1 : ih, 1);
      configure_frame(4'hF, 12'(iw), 12'(ih), 12'(ow), 12'(oh));
      frame_px = ((iw == 0) ? 1 : iw) * ((ih == 0) ? 1 : ih);
      if ($urandom_range(4) == 0) total = $urandom_range(frame_px, 1);
      else total = frame_px * $urandom_range(2, 1);
      repeat (total) send_pixel(pick_pixel());
      sent += total;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: one reset, directed cases, larger geometries, then random
  // frames under each gap mode, and the final verdict.
  // ---------------------------------------------------------------------------
  initial begin
    // Predictor state after reset: 640x480 down to 320x240, sums cleared.
    sz_in_w  = 12'd640;
    sz_in_h  = 12'd480;
    sz_out_w = 11'd320;
    sz_out_h = 12'd240;
    for (int i = 0; i < MAX_OUT_W; i++) begin
      acc_red[i]   = 0;
      acc_green[i] = 0;
      acc_blue[i]  = 0;
    end
    restart_frame();

    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    gap_mode = GAP_SEND_HEAVY;
    test_skipped_edges();
    test_zero_sizes();
    test_oversized_sizes();
    test_restart_on_write();
    test_tall_column();
    test_wide_block();

    test_random_frames(GAP_SEND_HEAVY, 110);
    test_random_frames(GAP_RECV_HEAVY, 110);
    test_random_frames(GAP_NONE, 110);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
